// ----- rtl/hssb_pkg.sv -----
// Shared types, constants and table functions of the Hilbert SSB frequency shifter.
package hssb_pkg;

    // Sample and phase step widths are fixed by the interface.
    localparam int SAMPLE_BITS = 16;
    localparam int STEP_BITS   = 32;
    localparam int TAP_BITS    = 18;
    localparam int SINE_ABITS  = 10;
    localparam int QUARTER     = 256;
    localparam int QSPAN       = 512;

    localparam longint INV_PI_Q32 = 64'sd1367130551;
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint Q30_ONE    = 64'sd1073741824;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 16'sh8000;

    localparam int QTAB_W = QUARTER * SAMPLE_BITS;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic signed [STEP_BITS-1:0]   phase_step;
    } smp_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] dry_out;
        logic signed [SAMPLE_BITS-1:0] shifted_out;
    } res_beat_t;

    // Quarter-wave sine in Q1.15 from an 11th-order Taylor sum in Q30.
    function automatic longint qsin(longint r);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint q;
        x    = r * PI_Q30 / QSPAN;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        term = (-term * x2) / Q30_ONE;
        term = term / 6;
        sum  = sum + term;
        term = (-term * x2) / Q30_ONE;
        term = term / 20;
        sum  = sum + term;
        term = (-term * x2) / Q30_ONE;
        term = term / 42;
        sum  = sum + term;
        term = (-term * x2) / Q30_ONE;
        term = term / 72;
        sum  = sum + term;
        term = (-term * x2) / Q30_ONE;
        term = term / 110;
        sum  = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (sum + 16384) >>> 15;
        if (q > 32767)
        begin
            q = 32767;
        end
        return q;
    endfunction

    function automatic logic [QTAB_W-1:0] build_qtab();
        logic [QTAB_W-1:0] t;
        t = '0;
        for (int i = 0; i < QUARTER; i++)
        begin
            t[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(qsin(longint'(i)));
        end
        return t;
    endfunction

    localparam logic [QTAB_W-1:0]      QTAB   = build_qtab();
    localparam logic [SAMPLE_BITS-1:0] QS_TOP = SAMPLE_BITS'(qsin(longint'(QUARTER)));

    // Full-period sine lookup built from the quarter table by symmetry.
    function automatic logic signed [SAMPLE_BITS-1:0] sine_at(logic [SINE_ABITS-1:0] a);
        logic [7:0]             r;
        logic [7:0]             ri;
        logic [SAMPLE_BITS-1:0] mag;
        r  = a[7:0];
        ri = 8'(9'd256 - {1'b0, r});
        if (a[8])
        begin
            if (r == 8'd0)
            begin
                mag = QS_TOP;
            end
            else
            begin
                mag = QTAB[ri*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        else
        begin
            mag = QTAB[r*SAMPLE_BITS +: SAMPLE_BITS];
        end
        return a[9] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ----- rtl/hssb_cell.sv -----
// One delay-line cell: a history register and a working copy for the tap walk.
module hssb_cell
    import hssb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic signed [SAMPLE_BITS-1:0] hist_in,
    input  logic                          adv,
    input  logic signed [SAMPLE_BITS-1:0] work_in,
    output logic signed [SAMPLE_BITS-1:0] hist,
    output logic signed [SAMPLE_BITS-1:0] work
);

    logic signed [SAMPLE_BITS-1:0] hist_reg;
    logic signed [SAMPLE_BITS-1:0] hist_next;
    logic signed [SAMPLE_BITS-1:0] work_reg;
    logic signed [SAMPLE_BITS-1:0] work_next;

    // On a new beat the history moves one place and the old value is copied for the walk.
    always_comb
    begin
        hist_next = shift ? hist_in : hist_reg;
        if (shift)
        begin
            work_next = hist_reg;
        end
        else if (adv)
        begin
            work_next = work_in;
        end
        else
        begin
            work_next = work_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign hist = hist_reg;
    assign work = work_reg;

endmodule

// ----- rtl/hilbert_ssb_frequency_shifter_top.sv -----
// Top level of the Hilbert SSB frequency shifter: cell chain, shared MAC and mixer.
//
//  channel | direction | handshake          | beat
//  smp     | in        | smp_valid/smp_stall| sample_in, phase_step
//  res     | out       | res_valid/res_stall| dry_out, shifted_out
//
// Each beat is accepted, then each odd tap pair goes through the single
// multiply-accumulate unit, the mixer states ST_MIX1 and ST_MIX2 follow and
// the output register is loaded once it is free.
// Reset clears the history cells, the phase accumulator and the control state.
// A stalled result waits in the output register while the next beat is taken.
module hilbert_ssb_frequency_shifter_top
    import hssb_pkg::*;
#(
    parameter int HALF_LEN   = 66,
    parameter int PHASE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      smp_valid,
    output logic      smp_stall,
    input  smp_beat_t smp_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_data
);

    localparam int NP  = HALF_LEN / 2;
    localparam int JW  = $clog2(NP);
    localparam int HL2 = 2 * HALF_LEN;
    localparam int QW  = SAMPLE_BITS + 26;
    localparam int MW  = QW + SAMPLE_BITS + 2;
    localparam int YW  = MW - 32;
    localparam int PW  = TAP_BITS + SAMPLE_BITS + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_MIX1 = 3'd2;
    localparam logic [2:0] ST_MIX2 = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic signed [YW-1:0] YMAX = YW'(SMP_MAX);
    localparam logic signed [YW-1:0] YMIN = YW'(SMP_MIN);
    localparam logic [MW-1:0]        RND  = {{(MW-32){1'b0}}, 1'b1, 31'b0};

    logic [2:0]                    state_reg, state_next;
    logic [JW-1:0]                 cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0]         phase_reg, phase_next;
    logic                          res_valid_reg, res_valid_next;
    logic [SINE_ABITS-1:0]         addr_reg, addr_next;
    logic signed [SAMPLE_BITS-1:0] dry_reg, dry_next;
    logic signed [QW-1:0]          acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] sin_reg, sin_next;
    logic signed [SAMPLE_BITS-1:0] cos_reg, cos_next;
    logic signed [QW+SAMPLE_BITS-1:0]   p1_reg, p1_next;
    logic signed [2*SAMPLE_BITS-1:0]    p2_reg, p2_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    res_beat_t                     out_reg, out_next;

    logic                          take;
    logic                          shift;
    logic                          adv;
    logic                          out_load;
    logic [TAP_BITS-1:0]           tap_tab [NP];
    logic signed [SAMPLE_BITS-1:0] hist_w [1:HL2];
    logic signed [SAMPLE_BITS-1:0] work_w [1:HL2];
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PW-1:0]          prod;
    logic signed [MW-1:0]          mix;
    logic signed [YW-1:0]          y_full;

    // Tap constants for the odd offsets, worked out at elaboration.
    for (genvar m = 0; m < NP; m++)
    begin : g_tap
        localparam longint K    = 2 * m + 1;
        localparam logic [TAP_BITS-1:0] TAPV =
            TAP_BITS'((INV_PI_Q32 + 64'sd8192 * K) / (64'sd16384 * K));
        assign tap_tab[m] = TAPV;
    end

    // Chain of cells: the upper half walks inward toward the center, the lower half too.
    for (genvar d = 1; d <= HL2; d++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] hin;
        logic signed [SAMPLE_BITS-1:0] win;
        if (d == 1)
        begin : g_first
            assign hin = smp_data.sample_in;
        end
        else
        begin : g_rest
            assign hin = hist_w[d-1];
        end
        if (d > HALF_LEN)
        begin : g_up
            if (d + 2 <= HL2)
            begin : g_src
                assign win = work_w[d+2];
            end
            else
            begin : g_zero
                assign win = '0;
            end
        end
        else if (d < HALF_LEN)
        begin : g_dn
            if (d >= 3)
            begin : g_src
                assign win = work_w[d-2];
            end
            else
            begin : g_zero
                assign win = '0;
            end
        end
        else
        begin : g_mid
            assign win = work_w[d];
        end
        hssb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .hist_in (hin),
            .adv     (adv),
            .work_in (win),
            .hist    (hist_w[d]),
            .work    (work_w[d])
        );
    end

    assign take     = smp_valid && !smp_stall;
    assign shift    = take;
    assign adv      = (state_reg == ST_MAC);
    assign out_load = (state_reg == ST_OUT) && (!res_valid_reg || !res_stall);

    // One tap pair per cycle: early minus late sample times the tap.
    assign diff   = {work_w[HALF_LEN+1][SAMPLE_BITS-1], work_w[HALF_LEN+1]}
                  - {work_w[HALF_LEN-1][SAMPLE_BITS-1], work_w[HALF_LEN-1]};
    assign prod   = PW'($signed({1'b0, tap_tab[cnt_reg]}) * diff);
    assign mix    = MW'(p1_reg) - (MW'(p2_reg) <<< 17) + $signed(RND);
    assign y_full = mix[MW-1:32];

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        res_valid_next = res_valid_reg;
        addr_next      = addr_reg;
        dry_next       = dry_reg;
        acc_next       = acc_reg;
        sin_next       = sin_reg;
        cos_next       = cos_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        y_next         = y_reg;
        out_next       = out_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    addr_next  = phase_reg[PHASE_BITS-1 -: SINE_ABITS];
                    phase_next = phase_reg + smp_data.phase_step[STEP_BITS-1 -: PHASE_BITS];
                    dry_next   = smp_data.sample_in;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next = acc_reg + QW'(prod);
                sin_next = sine_at(addr_reg);
                cos_next = sine_at(addr_reg + SINE_ABITS'(QUARTER));
                cnt_next = cnt_reg + JW'(1);
                if (cnt_reg == JW'(NP - 1))
                begin
                    state_next = ST_MIX1;
                end
            end
            ST_MIX1:
            begin
                p1_next    = acc_reg * cos_reg;
                p2_next    = work_w[HALF_LEN] * sin_reg;
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                if (y_full > YMAX)
                begin
                    y_next = SMP_MAX;
                end
                else if (y_full < YMIN)
                begin
                    y_next = SMP_MIN;
                end
                else
                begin
                    y_next = y_full[SAMPLE_BITS-1:0];
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_next.dry_out     = dry_reg;
                    out_next.shifted_out = y_reg;
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        dry_reg  <= dry_next;
        acc_reg  <= acc_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        y_reg    <= y_next;
        out_reg  <= out_next;
    end

    assign smp_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = out_reg;

endmodule

// ----- rtl/hssb_checker.sv -----
// Port-level checker for the Hilbert SSB frequency shifter, bound to the top level.
module hssb_checker
    import hssb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      smp_valid,
    input logic      smp_stall,
    input smp_beat_t smp_data,
    input logic      res_valid,
    input logic      res_stall,
    input res_beat_t res_data
);

    // A stalled result beat stays offered and unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // After a beat is taken the block is busy with it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> smp_stall)
        else $error("input taken again while a beat is in work");

    // A result never appears in the cycle right after an input beat.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> !$rose(res_valid))
        else $error("result appeared too early");

    // A new result only comes out of a busy period.
    a_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(smp_stall))
        else $error("result appeared with no beat in work");

    // The data input is read only on beats it belongs to.
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |-> !$isunknown(smp_data))
        else $error("unknown input beat taken");

endmodule

bind hilbert_ssb_frequency_shifter_top hssb_checker u_hssb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_data  (smp_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
